/* hdl/htj_pkg.sv */
// ----------------------------------------------------------------------------
// htj_pkg
// Types, register offsets and helper functions of the timer and joypad port.
// ----------------------------------------------------------------------------
package htj_pkg;

    // operation codes of an input item
    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_READ  = 2'd1,
        OP_WRITE = 2'd2
    } t_op;

    // io register offsets
    localparam logic [7:0] OFS_P1   = 8'h00;
    localparam logic [7:0] OFS_DIV  = 8'h04;
    localparam logic [7:0] OFS_TIMA = 8'h05;
    localparam logic [7:0] OFS_TMA  = 8'h06;
    localparam logic [7:0] OFS_TAC  = 8'h07;
    localparam logic [7:0] OFS_IF   = 8'h0F;

    localparam logic [7:0] IF_RESET     = 8'hE0;
    localparam logic [7:0] READ_UNKNOWN = 8'hFF;
    localparam int unsigned IRQ_TIMER_BIT = 2;

    // cycle counter only needs to resolve the largest divide (1024)
    localparam int unsigned CNT_W = 10;

    // joypad select codes (P1 bits 5:4)
    localparam logic [1:0] SEL_ACTION    = 2'b01;
    localparam logic [1:0] SEL_DIRECTION = 2'b10;

    // TAC clock select codes
    localparam logic [1:0] TAC_1024 = 2'd0;
    localparam logic [1:0] TAC_16   = 2'd1;
    localparam logic [1:0] TAC_64   = 2'd2;
    localparam logic [1:0] TAC_256  = 2'd3;

    typedef struct packed {
        t_op        operation;
        logic [7:0] reg_offset;
        logic [7:0] write_data;
        logic [7:0] buttons;
        logic       enter_stop;
    } t_in_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic       timer_irq;
        logic [7:0] irq_flags;
        logic       halted_by_stop;
    } t_out_item;

    // active-low nibble of the selected button group
    function automatic logic [3:0] pad_nibble(input logic [1:0] sel, input logic [7:0] btn);
        logic [3:0] nib;
        nib = 4'hF;
        if (sel == SEL_ACTION) begin
            nib = ~btn[3:0];
        end else if (sel == SEL_DIRECTION) begin
            nib = ~btn[7:4];
        end
        return nib;
    endfunction

    // true when the counter sits on a multiple of the selected divide
    function automatic logic tima_due(input logic [1:0] clk_sel, input logic [CNT_W-1:0] cnt);
        logic due;
        unique case (clk_sel)
            TAC_1024: due = (cnt[9:0] == '0);
            TAC_16:   due = (cnt[3:0] == '0);
            TAC_64:   due = (cnt[5:0] == '0);
            TAC_256:  due = (cnt[7:0] == '0);
            default:  due = 1'b0;
        endcase
        return due;
    endfunction

endpackage

/* hdl/htj_if.sv */
// ----------------------------------------------------------------------------
// htj channel interfaces
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface htj_in_if;
    logic              valid;
    logic              ready;
    htj_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface htj_out_if;
    logic               valid;
    logic               ready;
    htj_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hdl/handheld_timer_and_joypad_port_core.sv */
// result: registered, valid in the cycle after the item is accepted
// throughput: one item per cycle; a new item is taken while a result waits,
//   as long as the result register is empty or being emptied in that cycle
// reset: synchronous active-low i_rst_n clears all registers but the result data,
//   IF goes to 0xE0, the block takes items in the first cycle after reset
// ----------------------------------------------------------------------------
// handheld_timer_and_joypad_port_core
// DIV/TIMA timer, interrupt flag and joypad port with a stop latch. Each item
// is a tick, a register read or a register write and yields one result item.
// ----------------------------------------------------------------------------
module handheld_timer_and_joypad_port_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    htj_in_if.sink         i_in,
    htj_out_if.source      o_out
);

    localparam int unsigned CNT_W   = htj_pkg::CNT_W;
    localparam int unsigned IRQ_BIT = htj_pkg::IRQ_TIMER_BIT;

    logic [CNT_W-1:0]   r_cnt,     n_cnt;
    logic [7:0]         r_div,     n_div;
    logic [7:0]         r_tima,    n_tima;
    logic [7:0]         r_tma,     n_tma;
    logic [7:0]         r_tac,     n_tac;
    logic [7:0]         r_if,      n_if;
    logic [1:0]         r_pad_sel, n_pad_sel;
    logic [3:0]         r_pad_nib, n_pad_nib;
    logic               r_stop,    n_stop;

    logic               r_out_valid;
    htj_pkg::t_out_item r_out,     n_out;

    logic               in_ready;
    logic               in_accept;
    logic               stopped;
    htj_pkg::t_in_item  item;

    assign item      = i_in.data;
    assign in_ready  = !r_out_valid || o_out.ready;
    assign in_accept = i_in.valid && in_ready;

    assign i_in.ready  = in_ready;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    // a pressed button releases the latch before the timers look at it
    assign stopped = r_stop && (item.buttons == 8'h00);

    always_comb begin
        n_cnt     = r_cnt;
        n_div     = r_div;
        n_tima    = r_tima;
        n_tma     = r_tma;
        n_tac     = r_tac;
        n_if      = r_if;
        n_pad_sel = r_pad_sel;
        n_pad_nib = r_pad_nib;
        n_stop    = r_stop;
        n_out.read_data = 8'h00;
        n_out.timer_irq = 1'b0;

        unique case (item.operation)
            htj_pkg::OP_TICK: begin
                n_cnt     = r_cnt + CNT_W'(1);
                n_pad_nib = htj_pkg::pad_nibble(r_pad_sel, item.buttons);
                n_stop    = stopped;
                if (!stopped) begin
                    if (n_cnt[7:0] == 8'h00) begin
                        n_div = r_div + 8'd1;
                    end
                    if (r_tac[2] && htj_pkg::tima_due(r_tac[1:0], n_cnt)) begin
                        if (r_tima == 8'hFF) begin
                            n_tima = r_tma;
                            n_if[htj_pkg::IRQ_TIMER_BIT] = 1'b1;
                            n_out.timer_irq = 1'b1;
                        end else begin
                            n_tima = r_tima + 8'd1;
                        end
                    end
                end
                if (item.enter_stop) begin
                    n_stop = 1'b1;
                end
            end
            htj_pkg::OP_READ: begin
                unique case (item.reg_offset)
                    htj_pkg::OFS_P1:   n_out.read_data = {2'b00, r_pad_sel, r_pad_nib};
                    htj_pkg::OFS_DIV:  n_out.read_data = r_div;
                    htj_pkg::OFS_TIMA: n_out.read_data = r_tima;
                    htj_pkg::OFS_TMA:  n_out.read_data = r_tma;
                    htj_pkg::OFS_TAC:  n_out.read_data = r_tac;
                    htj_pkg::OFS_IF:   n_out.read_data = r_if;
                    default:           n_out.read_data = htj_pkg::READ_UNKNOWN;
                endcase
            end
            htj_pkg::OP_WRITE: begin
                unique case (item.reg_offset)
                    htj_pkg::OFS_P1:   n_pad_sel = item.write_data[5:4];
                    htj_pkg::OFS_DIV:  n_div     = 8'h00;
                    htj_pkg::OFS_TIMA: n_tima    = item.write_data;
                    htj_pkg::OFS_TMA:  n_tma     = item.write_data;
                    htj_pkg::OFS_TAC:  n_tac     = item.write_data;
                    htj_pkg::OFS_IF:   n_if      = item.write_data;
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase

        n_out.irq_flags      = n_if;
        n_out.halted_by_stop = n_stop;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_div       <= 8'h00;
            r_tima      <= 8'h00;
            r_tma       <= 8'h00;
            r_tac       <= 8'h00;
            r_if        <= htj_pkg::IF_RESET;
            r_pad_sel   <= 2'b00;
            r_pad_nib   <= 4'h0;
            r_stop      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_cnt     <= n_cnt;
                r_div     <= n_div;
                r_tima    <= n_tima;
                r_tma     <= n_tma;
                r_tac     <= n_tac;
                r_if      <= n_if;
                r_pad_sel <= n_pad_sel;
                r_pad_nib <= n_pad_nib;
                r_stop    <= n_stop;
            end
            if (in_accept) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out <= n_out;
        end
    end

`ifndef ASSERT_OFF
    // an overflow result always reports the timer flag set
    a_irq_sets_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.data.timer_irq |-> o_out.data.irq_flags[IRQ_BIT])
        else $error("timer_irq without IF timer bit");

    // only reads return data
    a_read_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && (item.operation != htj_pkg::OP_READ) |=> (r_out.read_data == 8'h00))
        else $error("nonzero read_data on a non-read item");

    // only ticks can overflow the timer
    a_irq_only_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && (item.operation != htj_pkg::OP_TICK) |=> !r_out.timer_irq)
        else $error("timer_irq on a non-tick item");

    // a latched stop with no button pressed freezes DIV on a tick
    a_stop_freezes_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && (item.operation == htj_pkg::OP_TICK) && stopped |=> $stable(r_div))
        else $error("DIV moved while stopped");
`endif

endmodule

/* tb/sv/tb_handheld_timer_and_joypad_port_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_handheld_timer_and_joypad_port_core
// Self-checking bench for the timer, interrupt flag and joypad port. Ticks,
// register reads, writes and unused operation codes go in under random gaps, and
// results come out under random stalls, with one long output hold-off. A
// scoreboard keeps its own copy of the registers, predicts every result and compares it field by field.
// ----------------------------------------------------------------------------
module tb_handheld_timer_and_joypad_port_core;

    // keeps a private copy of the port registers and the results they imply
    class timer_pad_scoreboard;
        bit [15:0] cycles;
        bit [7:0]  div_q;
        bit [7:0]  tima_q;
        bit [7:0]  tma_q;
        bit [7:0]  tac_q;
        bit [7:0]  if_q;
        bit [7:0]  p1_q;
        bit        stopped;
        htj_pkg::t_out_item expected_results[$];
        int unsigned mismatches;

        function new();
            cycles     = '0;
            div_q      = '0;
            tima_q     = '0;
            tma_q      = '0;
            tac_q      = '0;
            if_q       = htj_pkg::IF_RESET;
            p1_q       = '0;
            stopped    = 1'b0;
            mismatches = 0;
        endfunction

        function void note_item(htj_pkg::t_in_item it);
            htj_pkg::t_out_item res;
            logic [3:0]  nib;
            int unsigned period;
            res = '0;
            case (it.operation)
                htj_pkg::OP_TICK: begin
                    cycles = cycles + 16'd1;
                    case (p1_q[5:4])
                        htj_pkg::SEL_ACTION:    nib = ~it.buttons[3:0];
                        htj_pkg::SEL_DIRECTION: nib = ~it.buttons[7:4];
                        default:                nib = 4'hF;
                    endcase
                    p1_q[3:0] = nib;
                    if (stopped && it.buttons != 8'h00) begin
                        stopped = 1'b0;
                    end
                    if (!stopped) begin
                        if (cycles[7:0] == 8'h00) begin
                            div_q = div_q + 8'd1;
                        end
                        if (tac_q[2]) begin
                            case (tac_q[1:0])
                                htj_pkg::TAC_1024: period = 1024;
                                htj_pkg::TAC_16:   period = 16;
                                htj_pkg::TAC_64:   period = 64;
                                default:           period = 256;
                            endcase
                            if (int'(cycles) % period == 0) begin
                                if (tima_q == 8'hFF) begin
                                    tima_q = tma_q;
                                    if_q[htj_pkg::IRQ_TIMER_BIT] = 1'b1;
                                    res.timer_irq = 1'b1;
                                end else begin
                                    tima_q = tima_q + 8'd1;
                                end
                            end
                        end
                    end
                    if (it.enter_stop) begin
                        stopped = 1'b1;
                    end
                end
                htj_pkg::OP_READ: begin
                    case (it.reg_offset)
                        htj_pkg::OFS_P1:   res.read_data = p1_q;
                        htj_pkg::OFS_DIV:  res.read_data = div_q;
                        htj_pkg::OFS_TIMA: res.read_data = tima_q;
                        htj_pkg::OFS_TMA:  res.read_data = tma_q;
                        htj_pkg::OFS_TAC:  res.read_data = tac_q;
                        htj_pkg::OFS_IF:   res.read_data = if_q;
                        default:           res.read_data = htj_pkg::READ_UNKNOWN;
                    endcase
                end
                htj_pkg::OP_WRITE: begin
                    case (it.reg_offset)
                        htj_pkg::OFS_P1:   p1_q = {2'b00, it.write_data[5:4], p1_q[3:0]};
                        htj_pkg::OFS_DIV:  div_q = '0;
                        htj_pkg::OFS_TIMA: tima_q = it.write_data;
                        htj_pkg::OFS_TMA:  tma_q = it.write_data;
                        htj_pkg::OFS_TAC:  tac_q = it.write_data;
                        htj_pkg::OFS_IF:   if_q = it.write_data;
                        default:           ;
                    endcase
                end
                default: ;
            endcase
            res.irq_flags      = if_q;
            res.halted_by_stop = stopped;
            expected_results.push_back(res);
        endfunction

        function void check_result(htj_pkg::t_out_item got);
            htj_pkg::t_out_item want;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: result item with nothing pending: rd=%h irq=%b if=%h stop=%b",
                             $realtime, got.read_data, got.timer_irq, got.irq_flags,
                             got.halted_by_stop);
                end
                return;
            end
            want = expected_results.pop_front();
            if (got.read_data !== want.read_data || got.timer_irq !== want.timer_irq ||
                got.irq_flags !== want.irq_flags ||
                got.halted_by_stop !== want.halted_by_stop) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: result item differs", $realtime);
                    $display("  read_data      exp %h got %h", want.read_data, got.read_data);
                    $display("  timer_irq      exp %b got %b", want.timer_irq, got.timer_irq);
                    $display("  irq_flags      exp %h got %h", want.irq_flags, got.irq_flags);
                    $display("  halted_by_stop exp %b got %b", want.halted_by_stop,
                             got.halted_by_stop);
                end
            end
        endfunction

        function int unsigned pending();
            return expected_results.size();
        endfunction
    endclass

    localparam int unsigned ITEM_TARGET = 1675;

    logic i_clk;
    logic i_rst_n;

    htj_in_if  in_if ();
    htj_out_if out_if ();

    handheld_timer_and_joypad_port_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    timer_pad_scoreboard board = new();

    logic [7:0] io_offsets [6] = '{htj_pkg::OFS_P1, htj_pkg::OFS_DIV, htj_pkg::OFS_TIMA,
                                   htj_pkg::OFS_TMA, htj_pkg::OFS_TAC, htj_pkg::OFS_IF};

    int unsigned items_sent;
    int unsigned send_run_left;
    bit          send_calm;

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    function automatic htj_pkg::t_in_item bus_item(input logic [1:0] op,
                                                   input logic [7:0] ofs,
                                                   input logic [7:0] data,
                                                   input logic [7:0] btn,
                                                   input logic stop);
        htj_pkg::t_in_item it;
        it.operation  = htj_pkg::t_op'(op);
        it.reg_offset = ofs;
        it.write_data = data;
        it.buttons    = btn;
        it.enter_stop = stop;
        return it;
    endfunction

    task automatic send_item(input htj_pkg::t_in_item it);
        int unsigned gap;
        if (send_run_left == 0) begin
            send_run_left = $urandom_range(8, 48);
            send_calm     = ($urandom_range(0, 3) == 0);
        end
        send_run_left--;
        gap = send_calm ? 0 : $urandom_range(0, 16);
        if (gap != 0) begin
            @(negedge i_clk);
            in_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        in_if.valid <= 1'b1;
        in_if.data  <= it;
        do @(posedge i_clk); while (!in_if.ready);
        board.note_item(it);
        items_sent++;
    endtask

    task automatic pulse_tick(input logic [7:0] btn, input logic stop);
        send_item(bus_item(htj_pkg::OP_TICK, 8'($urandom), 8'($urandom), btn, stop));
    endtask

    task automatic read_reg(input logic [7:0] ofs);
        send_item(bus_item(htj_pkg::OP_READ, ofs, 8'($urandom), 8'($urandom), 1'($urandom)));
    endtask

    task automatic write_reg(input logic [7:0] ofs, input logic [7:0] data);
        send_item(bus_item(htj_pkg::OP_WRITE, ofs, data, 8'($urandom), 1'($urandom)));
    endtask

    // load TIMA close to overflow, pick a divide and let it run
    task automatic timer_run();
        logic [1:0]  sel;
        int unsigned n;
        sel = $urandom_range(0, 1) ? htj_pkg::TAC_16 : 2'($urandom_range(0, 3));
        write_reg(htj_pkg::OFS_TMA, 8'($urandom));
        write_reg(htj_pkg::OFS_TIMA, 8'($urandom_range(8'hF0, 8'hFF)));
        write_reg(htj_pkg::OFS_TAC, {5'($urandom), 1'($urandom_range(0, 5) != 0), sel});
        n = $urandom_range(10, 40);
        repeat (n) begin
            case ($urandom_range(0, 9))
                0: read_reg(io_offsets[$urandom_range(0, 5)]);
                1: write_reg(htj_pkg::OFS_IF, 8'($urandom));
                default: pulse_tick(($urandom_range(0, 2) == 0) ? 8'($urandom) : 8'h00,
                                    $urandom_range(0, 40) == 0);
            endcase
        end
    endtask

    // stop, sit frozen with no buttons, then wake on a press
    task automatic stop_run();
        int unsigned n;
        pulse_tick(8'h00, 1'b1);
        n = $urandom_range(3, 20);
        repeat (n) begin
            if ($urandom_range(0, 3) == 0) begin
                read_reg(($urandom_range(0, 1) == 0) ? htj_pkg::OFS_DIV : htj_pkg::OFS_TIMA);
            end else begin
                pulse_tick(8'h00, $urandom_range(0, 5) == 0);
            end
        end
        pulse_tick(8'($urandom_range(1, 255)), 1'b0);
        read_reg(htj_pkg::OFS_IF);
    endtask

    task automatic joypad_run();
        repeat (3) begin
            write_reg(htj_pkg::OFS_P1, 8'($urandom));
            pulse_tick(8'($urandom), 1'b0);
            read_reg(htj_pkg::OFS_P1);
        end
    endtask

    initial begin
        in_if.valid   = 1'b0;
        in_if.data    = '0;
        out_if.ready  = 1'b0;
        i_rst_n       = 1'b0;
        items_sent    = 0;
        send_run_left = 0;
        send_calm     = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset values and unknown offsets
        read_reg(htj_pkg::OFS_P1);
        read_reg(htj_pkg::OFS_DIV);
        read_reg(htj_pkg::OFS_TIMA);
        read_reg(htj_pkg::OFS_TMA);
        read_reg(htj_pkg::OFS_TAC);
        read_reg(htj_pkg::OFS_IF);
        read_reg(8'hFF);
        write_reg(8'h80, 8'hFF);
        // each joypad select code
        write_reg(htj_pkg::OFS_P1, 8'h10);
        pulse_tick(8'h5A, 1'b0);
        read_reg(htj_pkg::OFS_P1);
        write_reg(htj_pkg::OFS_P1, 8'hEF);
        pulse_tick(8'hA5, 1'b0);
        read_reg(htj_pkg::OFS_P1);
        write_reg(htj_pkg::OFS_P1, 8'h30);
        pulse_tick(8'hFF, 1'b0);
        read_reg(htj_pkg::OFS_P1);
        write_reg(htj_pkg::OFS_P1, 8'hCF);
        pulse_tick(8'h00, 1'b0);
        // stop latch set, held without buttons, released by a press
        pulse_tick(8'h00, 1'b1);
        pulse_tick(8'h00, 1'b0);
        pulse_tick(8'h80, 1'b0);
        write_reg(htj_pkg::OFS_DIV, 8'hFF);
        write_reg(htj_pkg::OFS_TAC, 8'hFF);
        // unused operation code
        send_item(bus_item(2'd3, htj_pkg::OFS_IF, 8'hFF, 8'hFF, 1'b1));

        while (items_sent < ITEM_TARGET) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: timer_run();
                5, 6:          stop_run();
                7:             joypad_run();
                8: begin
                    repeat (10) begin
                        send_item(bus_item(2'($urandom), 8'($urandom), 8'($urandom),
                                           8'($urandom), 1'($urandom)));
                    end
                end
                default: begin
                    write_reg(htj_pkg::OFS_DIV, 8'($urandom));
                    read_reg(htj_pkg::OFS_DIV);
                    read_reg(io_offsets[$urandom_range(0, 5)]);
                end
            endcase
        end

        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (board.mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // result side: random stalls, one long hold-off while the sender keeps going
    initial begin
        int unsigned results_taken;
        int unsigned stall;
        int unsigned run_left;
        bit          calm;
        results_taken = 0;
        run_left      = 0;
        calm          = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (run_left == 0) begin
                run_left = $urandom_range(8, 48);
                calm     = ($urandom_range(0, 3) == 0);
            end
            run_left--;
            stall = calm ? 0 : $urandom_range(0, 16);
            if (results_taken == 400) begin
                stall = 300;
            end
            if (stall != 0) begin
                @(negedge i_clk);
                out_if.ready <= 1'b0;
                repeat (stall - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            out_if.ready <= 1'b1;
            do @(posedge i_clk); while (!out_if.valid);
            board.check_result(out_if.data);
            results_taken++;
        end
    end

    initial begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
